/* src/ktl_pkg.sv */
// ----------------------------------------------------------------------------
// ktl_pkg
// Shared types, constants and character helpers of the keyword token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package ktl_pkg;

  localparam int unsigned MAX_TOKEN_LEN = 79;
  localparam int unsigned POS_WIDTH     = 32;
  localparam int unsigned NUM_KEYWORDS  = 7;
  localparam int unsigned LEN_WIDTH     = 7;
  localparam int unsigned START_WIDTH   = 32;
  localparam int unsigned KIND_WIDTH    = 4;
  localparam int unsigned DATA_WIDTH    = 40;

  localparam logic [3:0] KIND_SETUP        = 4'd0;
  localparam logic [3:0] KIND_DRAW         = 4'd1;
  localparam logic [3:0] KIND_TITLE        = 4'd2;
  localparam logic [3:0] KIND_WINDOW       = 4'd3;
  localparam logic [3:0] KIND_CLEAR        = 4'd4;
  localparam logic [3:0] KIND_FILL         = 4'd5;
  localparam logic [3:0] KIND_RECT         = 4'd6;
  localparam logic [3:0] KIND_IDENT        = 4'd7;
  localparam logic [3:0] KIND_INTEGER      = 4'd8;
  localparam logic [3:0] KIND_STRING       = 4'd9;
  localparam logic [3:0] KIND_LBRACE       = 4'd10;
  localparam logic [3:0] KIND_RBRACE       = 4'd11;
  localparam logic [3:0] KIND_BAD          = 4'd12;
  localparam logic [3:0] KIND_UNTERMINATED = 4'd13;
  localparam logic [3:0] KIND_END          = 4'd14;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic [LEN_WIDTH-1:0] MAX_LEN = LEN_WIDTH'(MAX_TOKEN_LEN);
  localparam logic [NUM_KEYWORDS-1:0] MASK_ALL = '1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_STRING,
    MODE_STOPPED
  } scan_mode_e;

  typedef struct packed {
    logic [KIND_WIDTH-1:0]  kind;
    logic [START_WIDTH-1:0] start;
    logic [LEN_WIDTH-1:0]   length;
    logic                   too_long;
    logic                   last;
  } result_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [LEN_WIDTH-1:0] kw_len(input int unsigned k);
    logic [LEN_WIDTH-1:0] len;
    case (k)
      0:       len = LEN_WIDTH'(5);
      1:       len = LEN_WIDTH'(4);
      2:       len = LEN_WIDTH'(5);
      3:       len = LEN_WIDTH'(6);
      4:       len = LEN_WIDTH'(5);
      5:       len = LEN_WIDTH'(4);
      default: len = LEN_WIDTH'(4);
    endcase
    return len;
  endfunction

  // keyword text left-aligned in six bytes, first char in the top byte
  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] idx);
    logic [47:0] txt;
    logic [47:0] sh;
    case (k)
      0:       txt = {"setup", 8'h00};
      1:       txt = {"draw", 16'h0000};
      2:       txt = {"title", 8'h00};
      3:       txt = "window";
      4:       txt = {"clear", 8'h00};
      5:       txt = {"fill", 16'h0000};
      default: txt = {"rect", 16'h0000};
    endcase
    sh = txt << (6'(idx) * 6'd8);
    return sh[47:40];
  endfunction

  function automatic logic [NUM_KEYWORDS-1:0] mask_next(
    input logic [NUM_KEYWORDS-1:0] mask,
    input logic [LEN_WIDTH-1:0]    run_len,
    input logic [7:0]              c
  );
    logic [NUM_KEYWORDS-1:0] m;
    m = mask;
    for (int unsigned k = 0; k < NUM_KEYWORDS; k++) begin
      if (run_len >= kw_len(k) || kw_char(k, run_len[2:0]) != c) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  // lowest matching keyword wins; keyword kinds equal their table index
  function automatic logic [KIND_WIDTH-1:0] word_kind(
    input logic [NUM_KEYWORDS-1:0] mask,
    input logic [LEN_WIDTH-1:0]    run_len,
    input logic                    ovf
  );
    logic [KIND_WIDTH-1:0] kind;
    kind = KIND_IDENT;
    if (!ovf) begin
      for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
        if (mask[k] && run_len == kw_len(k)) begin
          kind = KIND_WIDTH'(k);
        end
      end
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

/* src/keyword_token_lexer_top.sv */
// ----------------------------------------------------------------------------
// keyword_token_lexer_top
// Scans source bytes into keyword, identifier, integer, string, unterminated, brace, bad and end tokens.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | tuser      | tlast
//  s_axis   | in  | char_byte[7:0]                            | -          | -
//  m_axis   | out | token_start[31:0] token_length[6:0] too_long | token_kind | last
//
// one byte per cycle: input register, one scan stage, four-entry result queue
// an accepted byte waits in the input register, then its results are written into the queue that drives the bus
// a byte that closes a run or string and also yields a brace, end or bad result
// gives two results, so a stalled sink or a burst of such bytes backs up the
// queue; input waits when fewer than two queue slots are free
// ready right after reset; a bad char halts scanning until the next reset
`default_nettype none

module keyword_token_lexer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // char_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,   // token_start, token_length, too_long
  output logic [3:0]       m_axis_tuser_o,   // token_kind
  output logic             m_axis_tlast_o
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       adv;
  logic       in_acc;

  // scan state
  ktl_pkg::scan_mode_e                    mode_q, mode_d;
  logic [ktl_pkg::POS_WIDTH-1:0]          pos_q, pos_d;
  logic [ktl_pkg::POS_WIDTH-1:0]          start_q, start_d;
  logic [ktl_pkg::LEN_WIDTH-1:0]          rl_q, rl_d;
  logic [ktl_pkg::NUM_KEYWORDS-1:0]       mask_q, mask_d;
  logic                                   ovf_q, ovf_d;

  // result queue
  ktl_pkg::result_t  q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              pop;

  // per-byte results
  logic             prior_vld, sec_vld;
  ktl_pkg::result_t prior_res, sec_res, first_res, second_res;
  logic [1:0]       push_n;

  logic is_al, is_dg, is_sp;

  assign is_al = ktl_pkg::is_alpha(byte_q);
  assign is_dg = ktl_pkg::is_digit(byte_q);
  assign is_sp = ktl_pkg::is_space(byte_q);

  assign adv             = in_vld_q && (cnt_q <= QCNT_W'(QDEPTH - 2));
  assign s_axis_tready_o = !in_vld_q || adv;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= s_axis_tdata_i;
    end
  end

  // next scan state
  always_comb begin
    logic fresh;
    logic ext;
    logic ext_kw;
    mode_d  = mode_q;
    pos_d   = pos_q;
    start_d = start_q;
    rl_d    = rl_q;
    mask_d  = mask_q;
    ovf_d   = ovf_q;
    fresh   = 1'b0;
    ext     = 1'b0;
    ext_kw  = 1'b0;
    if (adv && mode_q != ktl_pkg::MODE_STOPPED) begin
      pos_d = pos_q + 1'b1;
      case (mode_q)
        ktl_pkg::MODE_WORD: begin
          if (is_al) begin
            ext    = 1'b1;
            ext_kw = 1'b1;
          end else begin
            fresh = 1'b1;
          end
        end
        ktl_pkg::MODE_NUMBER: begin
          if (is_dg) begin
            ext = 1'b1;
          end else begin
            fresh = 1'b1;
          end
        end
        ktl_pkg::MODE_STRING: begin
          if (byte_q == ktl_pkg::CH_QUOTE || byte_q == ktl_pkg::CH_NUL) begin
            mode_d = ktl_pkg::MODE_IDLE;
          end else begin
            ext = 1'b1;
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase
      if (ext) begin
        if (ext_kw) begin
          mask_d = ktl_pkg::mask_next(mask_q, rl_q, byte_q);
        end
        if (rl_q >= ktl_pkg::MAX_LEN) begin
          ovf_d = 1'b1;
        end else begin
          rl_d = rl_q + 1'b1;
        end
      end
      if (fresh) begin
        mode_d = ktl_pkg::MODE_IDLE;
        if (is_al || is_dg || byte_q == ktl_pkg::CH_QUOTE) begin
          mask_d  = ktl_pkg::MASK_ALL;
          ovf_d   = 1'b0;
          start_d = pos_q;
          rl_d    = ktl_pkg::LEN_WIDTH'(1);
          if (is_al) begin
            mode_d = ktl_pkg::MODE_WORD;
            mask_d = ktl_pkg::mask_next(ktl_pkg::MASK_ALL, '0, byte_q);
          end else if (is_dg) begin
            mode_d = ktl_pkg::MODE_NUMBER;
          end else begin
            mode_d  = ktl_pkg::MODE_STRING;
            start_d = pos_q + 1'b1;
            rl_d    = '0;
          end
        end else if (byte_q != ktl_pkg::CH_NUL && !is_sp &&
                     byte_q != ktl_pkg::CH_LBRACE && byte_q != ktl_pkg::CH_RBRACE) begin
          mode_d = ktl_pkg::MODE_STOPPED;
        end
      end
    end
  end

  // results of this byte: one closing a run or string, one from a fresh scan
  always_comb begin
    ktl_pkg::result_t fr;
    logic             fr_vld;
    fr.kind     = ktl_pkg::KIND_END;
    fr.start    = ktl_pkg::START_WIDTH'(pos_q);
    fr.length   = '0;
    fr.too_long = 1'b0;
    fr.last     = 1'b1;
    fr_vld      = 1'b1;
    if (byte_q == ktl_pkg::CH_NUL) begin
      fr.kind = ktl_pkg::KIND_END;
    end else if (byte_q == ktl_pkg::CH_LBRACE) begin
      fr.kind   = ktl_pkg::KIND_LBRACE;
      fr.length = ktl_pkg::LEN_WIDTH'(1);
    end else if (byte_q == ktl_pkg::CH_RBRACE) begin
      fr.kind   = ktl_pkg::KIND_RBRACE;
      fr.length = ktl_pkg::LEN_WIDTH'(1);
    end else if (is_sp || is_al || is_dg || byte_q == ktl_pkg::CH_QUOTE) begin
      fr_vld = 1'b0;
    end else begin
      fr.kind   = ktl_pkg::KIND_BAD;
      fr.length = ktl_pkg::LEN_WIDTH'(1);
    end

    prior_vld          = 1'b0;
    prior_res.kind     = ktl_pkg::KIND_IDENT;
    prior_res.start    = ktl_pkg::START_WIDTH'(start_q);
    prior_res.length   = rl_q;
    prior_res.too_long = ovf_q;
    prior_res.last     = 1'b0;
    sec_vld            = 1'b0;
    sec_res            = fr;
    if (adv) begin
      case (mode_q)
        ktl_pkg::MODE_STOPPED: begin
          sec_vld = 1'b0;
        end
        ktl_pkg::MODE_WORD: begin
          if (!is_al) begin
            prior_vld      = 1'b1;
            prior_res.kind = ktl_pkg::word_kind(mask_q, rl_q, ovf_q);
            sec_vld        = fr_vld;
          end
        end
        ktl_pkg::MODE_NUMBER: begin
          if (!is_dg) begin
            prior_vld      = 1'b1;
            prior_res.kind = ktl_pkg::KIND_INTEGER;
            sec_vld        = fr_vld;
          end
        end
        ktl_pkg::MODE_STRING: begin
          if (byte_q == ktl_pkg::CH_QUOTE) begin
            prior_vld      = 1'b1;
            prior_res.kind = ktl_pkg::KIND_STRING;
          end else if (byte_q == ktl_pkg::CH_NUL) begin
            prior_vld      = 1'b1;
            prior_res.kind = ktl_pkg::KIND_UNTERMINATED;
            sec_vld        = 1'b1;
          end
        end
        default: begin
          sec_vld = fr_vld;
        end
      endcase
    end

    first_res       = prior_vld ? prior_res : sec_res;
    first_res.last  = !(prior_vld && sec_vld);
    second_res      = sec_res;
    second_res.last = 1'b1;
    push_n          = {1'b0, prior_vld} + {1'b0, sec_vld};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ktl_pkg::MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      rl_q    <= '0;
      mask_q  <= ktl_pkg::MASK_ALL;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      rl_q    <= rl_d;
      mask_q  <= mask_d;
      ovf_q   <= ovf_d;
    end
  end

  // result queue
  assign pop   = m_axis_tvalid_o && m_axis_tready_i;
  assign cnt_d = cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_q] <= first_res;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_q + 1'b1] <= second_res;
    end
  end

  assign m_axis_tvalid_o = cnt_q != '0;
  assign m_axis_tdata_o  = {q_mem[rd_ptr_q].too_long, q_mem[rd_ptr_q].length,
                            q_mem[rd_ptr_q].start};
  assign m_axis_tuser_o  = q_mem[rd_ptr_q].kind;
  assign m_axis_tlast_o  = q_mem[rd_ptr_q].last;

endmodule

`default_nettype wire

/* src/ktl_checker.sv */
// ----------------------------------------------------------------------------
// ktl_checker
// Port-level checks of the keyword token lexer's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ktl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_i,
  input wire logic        m_tready_i,
  input wire logic [39:0] m_tdata_i,
  input wire logic [3:0]  m_tuser_i,
  input wire logic        m_tlast_i
);

  logic [6:0] tok_len;
  assign tok_len = m_tdata_i[38:32];

  // a stalled word holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=>
      m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i) &&
      $stable(m_tlast_i))
    else $error("result word changed while stalled");

  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> m_tuser_i <= ktl_pkg::KIND_END)
    else $error("token kind out of range");

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> tok_len <= ktl_pkg::MAX_LEN)
    else $error("token length above maximum");

  // overflow only after the count saturated
  a_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tdata_i[39] |-> tok_len == ktl_pkg::MAX_LEN)
    else $error("too_long without saturated length");

  // end of text is always the final word of its byte and has no span
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i == ktl_pkg::KIND_END |->
      m_tlast_i && tok_len == '0)
    else $error("malformed end-of-text word");

endmodule

bind keyword_token_lexer_top ktl_checker u_ktl_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o),
  .m_tlast_i  (m_axis_tlast_o)
);

`default_nettype wire

/* tb/keyword_token_lexer_checker.sv */
// ----------------------------------------------------------------------------
// keyword_token_lexer_checker
// Watches both stream channels of the lexer. Every byte taken on the input is
// run through a cycle-free token predictor, and every word on the output is
// compared field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_lexer_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  input  wire logic        s_tready_i,
  input  wire logic [7:0]  s_tdata_i,   // char_byte
  input  wire logic        m_tvalid_i,
  input  wire logic        m_tready_i,
  input  wire logic [39:0] m_tdata_i,   // token_start, token_length, too_long
  input  wire logic [3:0]  m_tuser_i,   // token_kind
  input  wire logic        m_tlast_i,
  output int               error_count_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  ktl_pkg::scan_mode_e                mode;
  logic [ktl_pkg::START_WIDTH-1:0]    byte_pos;
  logic [ktl_pkg::START_WIDTH-1:0]    run_start;
  logic [ktl_pkg::LEN_WIDTH-1:0]      run_len;
  logic [ktl_pkg::NUM_KEYWORDS-1:0]   kw_alive;
  logic                               run_over;

  ktl_pkg::result_t token_q[$];
  ktl_pkg::result_t step_tokens[2];
  int               step_count;

  function automatic string keyword_text(input int k);
    string s;
    case (k)
      0:       s = "setup";
      1:       s = "draw";
      2:       s = "title";
      3:       s = "window";
      4:       s = "clear";
      5:       s = "fill";
      default: s = "rect";
    endcase
    return s;
  endfunction

  function automatic bit letter_byte(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit digit_byte(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  task automatic reset_lexer();
    mode      = ktl_pkg::MODE_IDLE;
    byte_pos  = '0;
    run_start = '0;
    run_len   = '0;
    kw_alive  = '1;
    run_over  = 1'b0;
  endtask

  task automatic emit_token(input logic [3:0] kind, input logic [31:0] start,
                            input logic [6:0] len, input logic over);
    step_tokens[step_count].kind     = kind;
    step_tokens[step_count].start    = start;
    step_tokens[step_count].length   = len;
    step_tokens[step_count].too_long = over;
    step_tokens[step_count].last     = 1'b0;
    step_count++;
  endtask

  task automatic open_run(input ktl_pkg::scan_mode_e m, input logic [31:0] start);
    mode      = m;
    run_start = start;
    run_len   = '0;
    kw_alive  = '1;
    run_over  = 1'b0;
  endtask

  // one more byte in the run; count saturates, keyword candidates narrow down
  task automatic grow_run(input logic [7:0] c, input bit track_keywords);
    string s;
    if (track_keywords) begin
      for (int k = 0; k < ktl_pkg::NUM_KEYWORDS; k++) begin
        s = keyword_text(k);
        if (run_len >= s.len() || s[run_len] != c) begin
          kw_alive[k] = 1'b0;
        end
      end
    end
    if (run_len >= ktl_pkg::MAX_TOKEN_LEN) begin
      run_over = 1'b1;
    end else begin
      run_len = run_len + 1'b1;
    end
  endtask

  function automatic logic [3:0] word_result_kind();
    logic [3:0] kind;
    bit         found;
    string      s;
    kind  = ktl_pkg::KIND_IDENT;
    found = 1'b0;
    if (!run_over) begin
      for (int k = 0; k < ktl_pkg::NUM_KEYWORDS; k++) begin
        s = keyword_text(k);
        if (!found && kw_alive[k] && run_len == s.len()) begin
          kind  = 4'(k);
          found = 1'b1;
        end
      end
    end
    return kind;
  endfunction

  task automatic scan_fresh(input logic [7:0] c);
    if (c == ktl_pkg::CH_NUL) begin
      emit_token(ktl_pkg::KIND_END, byte_pos, '0, 1'b0);
    end else if (blank_byte(c)) begin
      // skipped
    end else if (letter_byte(c)) begin
      open_run(ktl_pkg::MODE_WORD, byte_pos);
      grow_run(c, 1'b1);
    end else if (digit_byte(c)) begin
      open_run(ktl_pkg::MODE_NUMBER, byte_pos);
      grow_run(c, 1'b0);
    end else if (c == ktl_pkg::CH_QUOTE) begin
      open_run(ktl_pkg::MODE_STRING, byte_pos + 1'b1);
    end else if (c == ktl_pkg::CH_LBRACE) begin
      emit_token(ktl_pkg::KIND_LBRACE, byte_pos, 7'd1, 1'b0);
    end else if (c == ktl_pkg::CH_RBRACE) begin
      emit_token(ktl_pkg::KIND_RBRACE, byte_pos, 7'd1, 1'b0);
    end else begin
      emit_token(ktl_pkg::KIND_BAD, byte_pos, 7'd1, 1'b0);
      mode = ktl_pkg::MODE_STOPPED;
    end
  endtask

  // predicts the tokens one source byte releases and queues them
  task automatic lex_byte(input logic [7:0] c);
    ktl_pkg::result_t tok;
    if (mode == ktl_pkg::MODE_STOPPED) begin
      return;
    end
    step_count = 0;
    case (mode)
      ktl_pkg::MODE_WORD: begin
        if (letter_byte(c)) begin
          grow_run(c, 1'b1);
        end else begin
          emit_token(word_result_kind(), run_start, run_len, run_over);
          mode = ktl_pkg::MODE_IDLE;
          scan_fresh(c);
        end
      end
      ktl_pkg::MODE_NUMBER: begin
        if (digit_byte(c)) begin
          grow_run(c, 1'b0);
        end else begin
          emit_token(ktl_pkg::KIND_INTEGER, run_start, run_len, run_over);
          mode = ktl_pkg::MODE_IDLE;
          scan_fresh(c);
        end
      end
      ktl_pkg::MODE_STRING: begin
        if (c == ktl_pkg::CH_QUOTE) begin
          emit_token(ktl_pkg::KIND_STRING, run_start, run_len, run_over);
          mode = ktl_pkg::MODE_IDLE;
        end else if (c == ktl_pkg::CH_NUL) begin
          emit_token(ktl_pkg::KIND_UNTERMINATED, run_start, run_len, run_over);
          emit_token(ktl_pkg::KIND_END, byte_pos, '0, 1'b0);
          mode = ktl_pkg::MODE_IDLE;
        end else begin
          grow_run(c, 1'b0);
        end
      end
      default: begin
        mode = ktl_pkg::MODE_IDLE;
        scan_fresh(c);
      end
    endcase
    byte_pos = byte_pos + 1'b1;
    for (int i = 0; i < step_count; i++) begin
      tok      = step_tokens[i];
      tok.last = (i == step_count - 1);
      token_q.push_back(tok);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count_o++;
    end
  endtask

  task automatic check_token();
    ktl_pkg::result_t want;
    if (token_q.size() == 0) begin
      $display("%0t: token with none expected, expected nothing, actual kind %0d start %0d",
               $time, m_tuser_i, m_tdata_i[31:0]);
      error_count_o++;
    end else begin
      want = token_q.pop_front();
      check_field("token_kind", 32'(want.kind), 32'(m_tuser_i));
      check_field("token_start", want.start, m_tdata_i[31:0]);
      check_field("token_length", 32'(want.length), 32'(m_tdata_i[38:32]));
      check_field("too_long", 32'(want.too_long), 32'(m_tdata_i[39]));
      check_field("last", 32'(want.last), 32'(m_tlast_i));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_lexer();
      token_q.delete();
      pending_o = 0;
    end else begin
      // prediction first: a token never leaves in the cycle its byte enters
      if (s_tvalid_i && s_tready_i) begin
        lex_byte(s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_token();
      end
      pending_o = token_q.size();
    end
  end

endmodule

`default_nettype wire

/* tb/tb_keyword_token_lexer_top.sv */
// ----------------------------------------------------------------------------
// tb_keyword_token_lexer_top
// Feeds source text into the lexer: a directed text with every keyword and
// token kind but bad, then random token sequences with noise, overlong
// runs and broken strings, under random gaps and sink stalls with one
// long hold-off. The run closes with an unknown byte that halts the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_keyword_token_lexer_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SOURCE_BYTES = 500;
  localparam int QUIET_TAIL   = 60;
  localparam int HOLD_AT      = 150;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        src_valid = 1'b0;
  logic        src_ready;
  logic [7:0]  src_byte  = 8'h00;
  logic        tok_valid;
  logic        tok_ready = 1'b0;
  logic [39:0] tok_data;   // token_start[31:0], token_length[38:32], too_long[39]
  logic [3:0]  tok_kind;   // token_kind
  logic        tok_last;
  int          error_count;
  int          pending;

  int lex_bytes   = 0;     // source bytes other than blanks
  int sent_bytes  = 0;
  int src_gap_pct = 10;
  bit tail_quiet  = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  keyword_token_lexer_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (src_valid),
    .s_axis_tready_o (src_ready),
    .s_axis_tdata_i  (src_byte),
    .m_axis_tvalid_o (tok_valid),
    .m_axis_tready_i (tok_ready),
    .m_axis_tdata_o  (tok_data),
    .m_axis_tuser_o  (tok_kind),
    .m_axis_tlast_o  (tok_last)
  );

  keyword_token_lexer_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_tvalid_i    (src_valid),
    .s_tready_i    (src_ready),
    .s_tdata_i     (src_byte),
    .m_tvalid_i    (tok_valid),
    .m_tready_i    (tok_ready),
    .m_tdata_i     (tok_data),
    .m_tuser_i     (tok_kind),
    .m_tlast_i     (tok_last),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  function automatic string keyword_name(input int k);
    string s;
    case (k)
      0:       s = "setup";
      1:       s = "draw";
      2:       s = "title";
      3:       s = "window";
      4:       s = "clear";
      5:       s = "fill";
      default: s = "rect";
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A" + r) : 8'("a" + r - 26);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? 8'h20 : 8'(r);
  endfunction

  // anything but the quote and NUL may sit inside a string, high bytes too
  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(1, 255));
    end while (b == ktl_pkg::CH_QUOTE);
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (!tail_quiet && $urandom_range(0, 99) < src_gap_pct) begin
      src_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte  <= b;
    do begin
      @(posedge clk);
    end while (!src_ready);
    if (!(b == 8'h20 || (b >= 8'h09 && b <= 8'h0d))) begin
      lex_bytes++;
    end
    sent_bytes++;
    if (sent_bytes % 40 == 0) begin
      case ($urandom_range(0, 2))
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 15;
        default: src_gap_pct = 40;
      endcase
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  // 0 letters, 1 digits, 2 string body
  task automatic send_run(input int what, input int n);
    for (int i = 0; i < n; i++) begin
      case (what)
        0:       send_byte(rand_letter());
        1:       send_byte(rand_digit());
        default: send_byte(rand_text_byte());
      endcase
    end
  endtask

  // exact keyword half the time, else clipped, extended or capitalized
  task automatic send_keyword();
    string      s;
    int         v;
    logic [7:0] c;
    s = keyword_name($urandom_range(0, ktl_pkg::NUM_KEYWORDS - 1));
    v = $urandom_range(0, 5);
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (v == 5 && i == 0) begin
        c = c - 8'h20;
      end
      if (!(v == 3 && i == s.len() - 1)) begin
        send_byte(c);
      end
    end
    if (v == 4) begin
      send_byte(rand_letter());
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 5))
      0:       send_byte(rand_letter());
      1:       send_byte(rand_digit());
      2:       send_byte(rand_blank());
      3:       send_byte(ktl_pkg::CH_QUOTE);
      4:       send_byte(ktl_pkg::CH_LBRACE);
      default: send_byte(ktl_pkg::CH_RBRACE);
    endcase
  endtask

  task automatic send_token();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      // overlong run straddling the saturation point
      n = $urandom_range(ktl_pkg::MAX_TOKEN_LEN - 2, ktl_pkg::MAX_TOKEN_LEN + 8);
      case ($urandom_range(0, 2))
        0: send_run(0, n);
        1: send_run(1, n);
        default: begin
          send_byte(ktl_pkg::CH_QUOTE);
          send_run(2, n);
          send_byte(ktl_pkg::CH_QUOTE);
        end
      endcase
    end else if (r < 30) begin
      send_keyword();
    end else if (r < 42) begin
      send_run(0, $urandom_range(1, 8));
    end else if (r < 54) begin
      send_run(1, $urandom_range(1, 6));
    end else if (r < 64) begin
      send_byte(ktl_pkg::CH_QUOTE);
      send_run(2, $urandom_range(0, 8));
      send_byte(ktl_pkg::CH_QUOTE);
    end else if (r < 70) begin
      send_byte(ktl_pkg::CH_LBRACE);
    end else if (r < 76) begin
      send_byte(ktl_pkg::CH_RBRACE);
    end else if (r < 80) begin
      send_byte(ktl_pkg::CH_NUL);
    end else if (r < 85) begin
      send_byte(ktl_pkg::CH_QUOTE);
      send_run(2, $urandom_range(0, 5));
      send_byte(ktl_pkg::CH_NUL);
    end else if (r < 92) begin
      send_noise();
    end else begin
      repeat ($urandom_range(1, 3)) send_byte(rand_blank());
    end
    // no separator half the time, so a run end and a new token share a byte
    if ($urandom_range(0, 1) == 0) begin
      send_byte(rand_blank());
    end
  endtask

  // sink side: random stall bursts, calm stretches, one long hold-off
  initial begin
    int gap_left;
    int sink_pct;
    int cyc;
    bit held;
    gap_left = 0;
    sink_pct = 20;
    cyc      = 0;
    held     = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && lex_bytes >= HOLD_AT) begin
        tok_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      cyc++;
      if (cyc % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       sink_pct = 0;
          1:       sink_pct = 20;
          default: sink_pct = 50;
        endcase
      end
      if (gap_left > 0) begin
        gap_left--;
        tok_ready <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 99) < sink_pct) begin
        gap_left = $urandom_range(1, 9) - 1;
        tok_ready <= 1'b0;
      end else begin
        tok_ready <= 1'b1;
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int random_target;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // every keyword, near misses, each token kind but bad, two tokens from one byte
    send_text("setup draw title window clear fill rect");
    send_byte(8'h09);
    send_text("setups Draw fil x9 0 12345{a}");
    send_byte(ktl_pkg::CH_NUL);
    send_text("\"\"{\"q r\"}ab\"x\"7");
    send_byte(ktl_pkg::CH_NUL);
    send_text("\"ab");
    send_byte(ktl_pkg::CH_NUL);
    send_byte(8'h0b);
    send_byte(8'h0c);

    // total byte budget covers the directed text too
    random_target = SOURCE_BYTES;
    while (sent_bytes < random_target) begin
      if (sent_bytes >= random_target - QUIET_TAIL) begin
        tail_quiet = 1'b1;
      end
      send_token();
    end

    // word closed by an unknown byte; the block halts after this
    send_text("tail");
    send_byte(8'($urandom_range(128, 255)));
    src_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* keyword_token_lexer_top.f */
src/ktl_pkg.sv
src/keyword_token_lexer_top.sv
src/ktl_checker.sv
tb/keyword_token_lexer_checker.sv
tb/tb_keyword_token_lexer_top.sv
